FILE: sv/eic_pkg.sv
// Shared types and constants for the edge interval capture block.
package eic_pkg;

  localparam int PIN_W  = 16;
  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_READ   = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  localparam logic [1:0] CFG_RISE_EN = 2'd0;
  localparam logic [1:0] CFG_FALL_EN = 2'd1;
  localparam logic [1:0] CFG_MASK    = 2'd2;

  typedef struct packed {
    logic capture;
    logic clear;
    logic rd_en;
  } lane_cmd_t;

  typedef struct packed {
    logic [DATA_W-1:0] count;
    logic [DATA_W-1:0] latest;
    logic [DATA_W-1:0] earlier;
  } lane_stat_t;

endpackage

FILE: sv/eic_lane.sv
// One capture lane: stamps, edge count and interval history ring of a single line.
module eic_lane import eic_pkg::*; #(
  parameter int RING_DEPTH = 8,
  parameter int SW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  lane_cmd_t         cmd,
  input  logic [DATA_W-1:0] tick,
  input  logic [SW-1:0]     rd_slot,
  output lane_stat_t        stat,
  output logic [DATA_W-1:0] rd_data,
  output logic              rd_hit
);

  localparam int FW = $clog2(RING_DEPTH + 1);

  logic [DATA_W-1:0] count_r, count_nxt;
  logic [DATA_W-1:0] latest_r, latest_nxt;
  logic [DATA_W-1:0] earlier_r, earlier_nxt;
  logic [SW-1:0]     wp_r, wp_nxt;
  logic [FW-1:0]     fill_r, fill_nxt;
  logic [DATA_W-1:0] rd_data_r;
  logic              rd_hit_r;

  logic [DATA_W-1:0] ring_mem [RING_DEPTH];

  always_comb begin
    count_nxt   = count_r;
    latest_nxt  = latest_r;
    earlier_nxt = earlier_r;
    wp_nxt      = wp_r;
    fill_nxt    = fill_r;
    if (cmd.clear) begin
      count_nxt   = '0;
      latest_nxt  = '0;
      earlier_nxt = '0;
      wp_nxt      = '0;
      fill_nxt    = '0;
    end else if (cmd.capture) begin
      count_nxt   = count_r + 1'b1;
      latest_nxt  = tick;
      earlier_nxt = latest_r;
      wp_nxt      = (wp_r == SW'(RING_DEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (fill_r != FW'(RING_DEPTH)) fill_nxt = fill_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      latest_r  <= '0;
      earlier_r <= '0;
      wp_r      <= '0;
      fill_r    <= '0;
    end else begin
      count_r   <= count_nxt;
      latest_r  <= latest_nxt;
      earlier_r <= earlier_nxt;
      wp_r      <= wp_nxt;
      fill_r    <= fill_nxt;
    end
  end

  // slots at or above the fill count have not been written since clear/reset
  always_ff @(posedge clk) begin
    if (cmd.capture) ring_mem[wp_r] <= tick - latest_r;
    if (cmd.rd_en) begin
      rd_data_r <= ring_mem[rd_slot];
      rd_hit_r  <= (FW'(rd_slot) < fill_r);
    end
  end

  assign stat.count   = count_r;
  assign stat.latest  = latest_r;
  assign stat.earlier = earlier_r;
  assign rd_data      = rd_data_r;
  assign rd_hit       = rd_hit_r;

endmodule

FILE: sv/eic_merge.sv
// Merge stage: picks the addressed lane and holds the result register.
module eic_merge import eic_pkg::*; #(
  parameter int LINE_COUNT = 16,
  parameter int LW = (LINE_COUNT > 1) ? $clog2(LINE_COUNT) : 1
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                acc,
  input  op_t                                 op,
  input  logic                                line_ok,
  input  logic [LW-1:0]                       line_sel,
  input  logic [PIN_W-1:0]                    pending_nxt,
  input  logic [PIN_W-1:0]                    events,
  input  lane_stat_t [LINE_COUNT-1:0]         lane_stat,
  input  logic [LINE_COUNT-1:0][DATA_W-1:0]   lane_rdata,
  input  logic [LINE_COUNT-1:0]               lane_hit,
  input  logic                                out_tready,
  output logic                                out_tvalid,
  // pending_bits, new_events, event_total, latest_time, earlier_time, slot_interval
  output logic [2*PIN_W+4*DATA_W-1:0]         out_tdata
);

  logic              valid_r, valid_nxt;
  logic [PIN_W-1:0]  pend_r, evt_r;
  logic [DATA_W-1:0] total_r, latest_r, earlier_r;
  logic              rd_r;
  logic [LW-1:0]     sel_r;
  lane_stat_t        pick;
  logic              is_read;
  logic [DATA_W-1:0] interval;

  assign is_read = (op == OP_READ) && line_ok;
  assign pick    = is_read ? lane_stat[line_sel] : '0;

  always_comb begin
    valid_nxt = valid_r;
    if (acc) valid_nxt = 1'b1;
    else if (out_tready) valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else valid_r <= valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      pend_r    <= pending_nxt;
      evt_r     <= (op == OP_SAMPLE) ? events : '0;
      total_r   <= pick.count;
      latest_r  <= pick.latest;
      earlier_r <= pick.earlier;
      rd_r      <= is_read;
      sel_r     <= line_sel;
    end
  end

  // lane read data is registered in the lane and holds until the next read
  assign interval = (rd_r && lane_hit[sel_r]) ? lane_rdata[sel_r] : '0;

  assign out_tvalid = valid_r;
  assign out_tdata  = {interval, earlier_r, latest_r, total_r, evt_r, pend_r};

endmodule

FILE: sv/edge_interval_capture.sv
// Top level of the edge interval capture block: config, edge detect, lanes and merge.
//
// Takes one request per clock while in_tready is high: sample (levels in, tick
// advances), read of one line's record and history slot, clear of one line plus all
// pending flags, or spare (no state change). Every request gives exactly one result,
// registered on acceptance; in_tready stays high while the result register is empty
// or being drained, so requests stream back to back at one per cycle while results are
// taken. Each line is a lane with its own stamps, counter and history ring memory; the
// ring read is registered in the lane with the result. Slots never written since reset
// or the last clear read as zero via a per-lane fill count; reset needs no clearing pass.
module edge_interval_capture import eic_pkg::*; #(
  parameter int RING_DEPTH = 8,
  parameter int LINE_COUNT = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // pin_levels [15:0], line_index [19:16], slot_index [22:20], zero [23]
  input  logic [23:0]                 in_tdata,
  // opcode [1:0]
  input  logic [1:0]                  in_tuser,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // pending_bits [15:0], new_events [31:16], event_total [63:32],
  // latest_time [95:64], earlier_time [127:96], slot_interval [159:128]
  output logic [2*PIN_W+4*DATA_W-1:0] out_tdata,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [1:0]                  cfg_index,
  input  logic [PIN_W-1:0]            cfg_data
);

  localparam int LW = (LINE_COUNT > 1) ? $clog2(LINE_COUNT) : 1;
  localparam int SW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam logic [PIN_W-1:0] LMASK =
    (LINE_COUNT >= PIN_W) ? {PIN_W{1'b1}} : PIN_W'((32'd1 << LINE_COUNT) - 32'd1);

  logic [PIN_W-1:0]  rise_en_r, fall_en_r, mask_r;
  logic [PIN_W-1:0]  hist_r, hist_nxt;
  logic [PIN_W-1:0]  pending_r, pending_nxt;
  logic [DATA_W-1:0] tick_r, tick_nxt;

  logic              acc;
  op_t               op;
  logic [PIN_W-1:0]  pins;
  logic [3:0]        line_idx;
  logic [2:0]        slot_idx;
  logic [5:0]        line_ext;
  logic              line_ok;
  logic [LW-1:0]     line_sel;
  logic [6:0]        slot_red;
  logic [SW-1:0]     slot_sel;
  logic [PIN_W-1:0]  events;

  lane_stat_t [LINE_COUNT-1:0]       lane_stat;
  logic [LINE_COUNT-1:0][DATA_W-1:0] lane_rdata;
  logic [LINE_COUNT-1:0]             lane_hit;

  assign pins     = in_tdata[15:0];
  assign line_idx = in_tdata[19:16];
  assign slot_idx = in_tdata[22:20];
  assign op       = op_t'(in_tuser);

  assign in_tready = !out_tvalid || out_tready;
  assign acc       = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign line_ext = {2'b00, line_idx};
  assign line_ok  = (line_ext < 6'(LINE_COUNT));
  assign line_sel = line_ext[LW-1:0];

  // slot modulo ring depth by repeated subtraction on a 3-bit value
  always_comb begin
    slot_red = {4'b0000, slot_idx};
    for (int k = 0; k < 8; k++) begin
      if (slot_red >= 7'(RING_DEPTH)) slot_red = slot_red - 7'(RING_DEPTH);
    end
  end
  assign slot_sel = slot_red[SW-1:0];

  assign events = ((~hist_r & pins & rise_en_r) | (hist_r & ~pins & fall_en_r))
                  & mask_r & LMASK;

  always_comb begin
    hist_nxt    = hist_r;
    tick_nxt    = tick_r;
    pending_nxt = pending_r;
    case (op)
      OP_SAMPLE: begin
        hist_nxt    = pins;
        tick_nxt    = tick_r + 1'b1;
        pending_nxt = pending_r | events;
      end
      OP_CLEAR: pending_nxt = '0;
      default:  pending_nxt = pending_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r    <= '0;
      tick_r    <= '0;
      pending_r <= '0;
    end else if (acc) begin
      hist_r    <= hist_nxt;
      tick_r    <= tick_nxt;
      pending_r <= pending_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rise_en_r <= '0;
      fall_en_r <= '0;
      mask_r    <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_RISE_EN: rise_en_r <= cfg_data;
        CFG_FALL_EN: fall_en_r <= cfg_data;
        CFG_MASK:    mask_r    <= cfg_data;
        default:     ;
      endcase
    end
  end

  for (genvar i = 0; i < LINE_COUNT; i++) begin : g_lane
    lane_cmd_t cmd;
    logic      cap;
    logic      hit_line;

    if (i < PIN_W) begin : g_pin
      assign cap = events[i];
    end else begin : g_nopin
      assign cap = 1'b0;
    end

    assign hit_line    = line_ok && (line_sel == LW'(i));
    assign cmd.capture = acc && (op == OP_SAMPLE) && cap;
    assign cmd.clear   = acc && (op == OP_CLEAR) && hit_line;
    assign cmd.rd_en   = acc && (op == OP_READ) && hit_line;

    eic_lane #(
      .RING_DEPTH (RING_DEPTH),
      .SW         (SW)
    ) u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .cmd     (cmd),
      .tick    (tick_r),
      .rd_slot (slot_sel),
      .stat    (lane_stat[i]),
      .rd_data (lane_rdata[i]),
      .rd_hit  (lane_hit[i])
    );
  end

  eic_merge #(
    .LINE_COUNT (LINE_COUNT),
    .LW         (LW)
  ) u_merge (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc         (acc),
    .op          (op),
    .line_ok     (line_ok),
    .line_sel    (line_sel),
    .pending_nxt (pending_nxt),
    .events      (events),
    .lane_stat   (lane_stat),
    .lane_rdata  (lane_rdata),
    .lane_hit    (lane_hit),
    .out_tready  (out_tready),
    .out_tvalid  (out_tvalid),
    .out_tdata   (out_tdata)
  );

  a_tick_step: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && (op == OP_SAMPLE)) |=> (tick_r == $past(tick_r) + 32'd1))
    else $error("tick did not advance on sample");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> out_tvalid)
    else $error("accepted request gave no result");

  a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && (op == OP_CLEAR)) |=> (out_tdata[15:0] == '0))
    else $error("clear left pending flags set");

  a_events_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata[31:16] & ~out_tdata[15:0]) == '0))
    else $error("new event without pending flag");

  a_pending_lines: assert property (@(posedge clk) disable iff (!rst_n)
    ((pending_r & ~LMASK) == '0))
    else $error("pending flag on absent line");

endmodule

FILE: test/edge_interval_checker.sv
`timescale 1ns / 100ps
// Checker for edge_interval_capture: watches all three channels, predicts and compares results.
module edge_interval_checker import eic_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  input  logic                        in_tready,
  input  logic [23:0]                 in_tdata,
  input  logic [1:0]                  in_tuser,
  input  logic                        out_tvalid,
  input  logic                        out_tready,
  input  logic [2*PIN_W+4*DATA_W-1:0] out_tdata,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [1:0]                  cfg_index,
  input  logic [PIN_W-1:0]            cfg_data,
  output int                          mismatches,
  output int                          awaited
);

  localparam int LINES = 16;
  localparam int SLOTS = 8;

  typedef struct packed {
    logic [PIN_W-1:0]  pending_bits;
    logic [PIN_W-1:0]  new_events;
    logic [DATA_W-1:0] event_total;
    logic [DATA_W-1:0] latest_time;
    logic [DATA_W-1:0] earlier_time;
    logic [DATA_W-1:0] slot_interval;
  } line_report_t;

  logic [PIN_W-1:0]  rise_en, fall_en, unmasked;
  logic [PIN_W-1:0]  prev_levels, pend;
  logic [DATA_W-1:0] tick;
  logic [DATA_W-1:0] last_tick [LINES];
  logic [DATA_W-1:0] prior_tick [LINES];
  logic [DATA_W-1:0] hits [LINES];
  logic [DATA_W-1:0] intervals [LINES][SLOTS];
  line_report_t      report_q [$];

  // Applies one request to the shadow state and returns the report it should produce.
  function automatic line_report_t apply_request(logic [1:0] op, logic [PIN_W-1:0] pins,
                                                 logic [3:0] line, logic [2:0] slot);
    line_report_t     r;
    logic [PIN_W-1:0] fired;
    r = '0;
    case (op)
      OP_SAMPLE: begin
        fired = ((~prev_levels & pins & rise_en) | (prev_levels & ~pins & fall_en)) & unmasked;
        for (int i = 0; i < LINES; i++) begin
          if (fired[i]) begin
            // stamp uses the tick before this sample's increment
            prior_tick[i] = last_tick[i];
            last_tick[i] = tick;
            intervals[i][hits[i] % SLOTS] = tick - prior_tick[i];
            hits[i] = hits[i] + 1;
          end
        end
        pend = pend | fired;
        prev_levels = pins;
        tick = tick + 1;
        r.new_events = fired;
      end
      OP_READ: begin
        r.event_total = hits[line];
        r.latest_time = last_tick[line];
        r.earlier_time = prior_tick[line];
        r.slot_interval = intervals[line][slot % SLOTS];
      end
      OP_CLEAR: begin
        last_tick[line] = '0;
        prior_tick[line] = '0;
        hits[line] = '0;
        for (int s = 0; s < SLOTS; s++) intervals[line][s] = '0;
        pend = '0;
      end
      default: ;  // spare opcode leaves everything alone
    endcase
    r.pending_bits = pend;
    return r;
  endfunction

  task automatic check_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    line_report_t want;
    if (!rst_n) begin
      rise_en = '0;
      fall_en = '0;
      unmasked = '0;
      prev_levels = '0;
      pend = '0;
      tick = '0;
      for (int i = 0; i < LINES; i++) begin
        last_tick[i] = '0;
        prior_tick[i] = '0;
        hits[i] = '0;
        for (int s = 0; s < SLOTS; s++) intervals[i][s] = '0;
      end
      report_q.delete();
      mismatches = 0;
    end else begin
      // results are registered, so the one leaving now belongs to an older request
      if (out_tvalid && out_tready) begin
        if (report_q.size() == 0) begin
          $error("result with no request outstanding");
          mismatches++;
        end else begin
          want = report_q.pop_front();
          check_field("pending_bits", DATA_W'(want.pending_bits), DATA_W'(out_tdata[15:0]));
          check_field("new_events", DATA_W'(want.new_events), DATA_W'(out_tdata[31:16]));
          check_field("event_total", want.event_total, out_tdata[63:32]);
          check_field("latest_time", want.latest_time, out_tdata[95:64]);
          check_field("earlier_time", want.earlier_time, out_tdata[127:96]);
          check_field("slot_interval", want.slot_interval, out_tdata[159:128]);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_RISE_EN: rise_en = cfg_data;
          CFG_FALL_EN: fall_en = cfg_data;
          CFG_MASK:    unmasked = cfg_data;
          default:     ;
        endcase
      end
      if (in_tvalid && in_tready)
        report_q.push_back(apply_request(in_tuser, in_tdata[15:0], in_tdata[19:16],
                                         in_tdata[22:20]));
    end
    awaited = report_q.size();
  end

endmodule

FILE: test/tb_edge_interval_capture.sv
`timescale 1ns / 100ps
// Testbench top for edge_interval_capture: clock, reset, stimulus and verdict.
module tb_edge_interval_capture;
  import eic_pkg::*;

  localparam logic [1:0] OP_SPARE = 2'd3;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_tvalid = 1'b0;
  logic                        in_tready;
  logic [23:0]                 in_tdata = '0;
  logic [1:0]                  in_tuser = OP_SAMPLE;
  logic                        out_tvalid;
  logic                        out_tready = 1'b0;
  logic [2*PIN_W+4*DATA_W-1:0] out_tdata;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [1:0]                  cfg_index = CFG_RISE_EN;
  logic [PIN_W-1:0]            cfg_data = '0;
  int                          mismatches;
  int                          awaited;

  logic [PIN_W-1:0]            level_shadow = '0;
  int                          burst_left = 0;

  always #5 clk = ~clk;

  edge_interval_capture uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  edge_interval_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .awaited    (awaited)
  );

  // Receiver back-pressure: a mode is held for a stretch, then another is picked.
  always @(negedge clk) begin
    int stall_left;
    int stall_mode;
    int beat;
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(40, 300);
    end else begin
      stall_left = stall_left - 1;
    end
    beat = beat + 1;
    case (stall_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= ($urandom_range(0, 3) != 0);
      2:       out_tready <= (beat % 5 != 0);
      default: out_tready <= ($urandom_range(0, 15) == 0);
    endcase
  end

  // Called at a falling edge; returns at the falling edge after the write is taken.
  task automatic write_reg(input logic [1:0] idx, input logic [PIN_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic set_enables(input logic [PIN_W-1:0] rise, input logic [PIN_W-1:0] fall,
                             input logic [PIN_W-1:0] mask);
    write_reg(CFG_RISE_EN, rise);
    write_reg(CFG_FALL_EN, fall);
    write_reg(CFG_MASK, mask);
    cfg_valid <= 1'b0;
  endtask

  // Issues one request, with a random gap first whenever a burst has run out.
  task automatic send(input logic [1:0] op, input logic [PIN_W-1:0] pins,
                      input logic [3:0] line, input logic [2:0] slot);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = $urandom_range(0, 10);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left = burst_left - 1;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {1'b0, slot, line, pins};
    if (op == OP_SAMPLE) level_shadow = pins;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Stops the sender and waits for every outstanding result to drain.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (awaited != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic random_request();
    int               pick;
    logic [PIN_W-1:0] pins;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      // mostly sparse toggles so lines see real edge trains
      case ($urandom_range(0, 3))
        0:       pins = PIN_W'($urandom);
        1:       pins = level_shadow;
        default: pins = level_shadow ^ (PIN_W'($urandom) & PIN_W'($urandom) & PIN_W'($urandom));
      endcase
      send(OP_SAMPLE, pins, 4'($urandom), 3'($urandom));
    end else if (pick < 88) begin
      send(OP_READ, PIN_W'($urandom), 4'($urandom), 3'($urandom));
    end else if (pick < 95) begin
      send(OP_CLEAR, PIN_W'($urandom), 4'($urandom), 3'($urandom));
    end else begin
      send(OP_SPARE, PIN_W'($urandom), 4'($urandom), 3'($urandom));
    end
  endtask

  initial begin
    logic [PIN_W-1:0] rise, fall, mask;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    set_enables(16'hffff, 16'hffff, 16'hffff);
    send(OP_SAMPLE, 16'hffff, 4'd0, 3'd0);  // high on first sample: rising everywhere
    send(OP_READ, 16'h0000, 4'd0, 3'd0);
    send(OP_SAMPLE, 16'h0000, 4'd0, 3'd0);  // falling everywhere
    send(OP_SAMPLE, 16'h0000, 4'd0, 3'd0);  // no edge
    send(OP_READ, 16'h0000, 4'd15, 3'd1);
    send(OP_SAMPLE, 16'h8001, 4'd0, 3'd0);
    send(OP_SAMPLE, 16'h7ffe, 4'd0, 3'd0);
    send(OP_READ, 16'h0000, 4'd15, 3'd7);
    send(OP_READ, 16'h0000, 4'd8, 3'd2);
    send(OP_SPARE, 16'hffff, 4'd15, 3'd7);
    send(OP_READ, 16'hffff, 4'd0, 3'd4);
    send(OP_CLEAR, 16'h0000, 4'd15, 3'd0);  // drops all pending bits
    send(OP_READ, 16'h0000, 4'd15, 3'd1);
    send(OP_READ, 16'h0000, 4'd0, 3'd2);
    send(OP_SAMPLE, 16'haaaa, 4'd0, 3'd0);
    send(OP_SAMPLE, 16'h5555, 4'd0, 3'd0);
    send(OP_READ, 16'h0000, 4'd10, 3'd3);
    send(OP_CLEAR, 16'hffff, 4'd0, 3'd7);
    send(OP_READ, 16'h0000, 4'd0, 3'd0);
    send(OP_SAMPLE, 16'h0000, 4'd0, 3'd0);

    for (int phase = 0; phase < 8; phase++) begin
      settle();
      rise = PIN_W'($urandom);
      fall = PIN_W'($urandom);
      mask = PIN_W'($urandom);
      case (phase)
        0: set_enables(16'hffff, 16'hffff, 16'hffff);
        1: set_enables(16'h0000, 16'h0000, 16'h0000);
        2: set_enables(16'hffff, 16'h0000, 16'hffff);
        3: set_enables(16'h0000, 16'hffff, mask);
        5: set_enables(rise, fall, 16'hffff);
        6: set_enables(16'hffff, 16'hffff, 16'h0000);
        default: set_enables(rise, fall, mask);
      endcase
      repeat (235) random_request();
    end

    settle();
    if (mismatches == 0)
      $display("edge_interval_capture: match");
    else
      $display("edge_interval_capture: mismatch");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("edge_interval_capture: mismatch");
    $finish;
  end

endmodule
